FILE: sv/sefa_pkg.sv
package sefa_pkg;

   localparam int MaxExtents = 1024;
   localparam int IdxW       = $clog2(MaxExtents);
   localparam int CntW       = $clog2(MaxExtents + 1);
   localparam int AddrBits   = 48;
   localparam int ValW       = AddrBits + 2;
   localparam int AlignW     = 21;
   localparam int ReserveW   = 32;
   localparam int CsrIdxW    = 1;
   localparam int CsrDataW   = 32;
   localparam int ModeW      = 3;
   localparam int StatusW    = 3;
   localparam int LayoutW    = 11;
   localparam int GapsW      = 11;
   localparam int CmpW       = (CntW > LayoutW) ? CntW : LayoutW;
   localparam int RndCntW    = $clog2(ValW + 1);

   localparam logic [AddrBits-1:0] Mask48     = {AddrBits{1'b1}};
   localparam logic [AlignW-1:0]   AlignReset = AlignW'(4096);

   localparam logic [ModeW-1:0] ModeFirstFit = 3'd0;
   localparam logic [ModeW-1:0] ModeAllocAt  = 3'd1;
   localparam logic [ModeW-1:0] ModeFree     = 3'd2;
   localparam logic [ModeW-1:0] ModeSizeQ    = 3'd3;
   localparam logic [ModeW-1:0] ModeLimit    = 3'd4;
   localparam logic [ModeW-1:0] ModeNth      = 3'd5;
   localparam logic [ModeW-1:0] ModeStats    = 3'd6;

   localparam logic [StatusW-1:0] StOk        = 3'd0;
   localparam logic [StatusW-1:0] StFull      = 3'd1;
   localparam logic [StatusW-1:0] StNotFound  = 3'd2;
   localparam logic [StatusW-1:0] StBadIndex  = 3'd3;
   localparam logic [StatusW-1:0] StBadOffset = 3'd4;
   localparam logic [StatusW-1:0] StOverflow  = 3'd5;

   localparam logic [CsrIdxW-1:0] CsrReserve = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrAlign   = 1'b1;

   typedef struct packed {
      logic [ModeW-1:0]    mode;
      logic [AddrBits-1:0] req_size;
      logic [AddrBits-1:0] req_offset;
      logic [LayoutW-1:0]  layout_index;
      logic [AddrBits-1:0] file_size;
   } sefa_req_type;

   typedef struct packed {
      logic [StatusW-1:0]  status;
      logic [AddrBits-1:0] result_offset;
      logic [AddrBits-1:0] result_size;
      logic [AddrBits-1:0] free_bytes;
      logic [GapsW-1:0]    free_gaps;
      logic [AddrBits-1:0] largest_gap;
   } sefa_rsp_type;

   typedef struct packed {
      logic [AddrBits-1:0] off;
      logic [AddrBits-1:0] size;
   } sefa_entry_type;

   typedef struct packed {
      logic done;
      logic exact;
   } sefa_rnd_stat_type;

endpackage

FILE: sv/sefa_ram.sv
module sefa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/sefa_rnd.sv
// Rounds a value up to a multiple of the alignment: restoring remainder,
// one quotient bit per cycle, then one add.
module sefa_rnd (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sefa_pkg::ValW-1:0]       value,
   input  logic [sefa_pkg::AlignW-1:0]     align,
   output logic [sefa_pkg::ValW-1:0]       rounded,
   output sefa_pkg::sefa_rnd_stat_type     stat
);

   typedef enum logic [1:0] {R_IDLE, R_DIV, R_FIX} state_type;

   state_type                       state_ff;
   logic [sefa_pkg::ValW-1:0]       orig_ff;
   logic [sefa_pkg::ValW-1:0]       shift_ff;
   logic [sefa_pkg::AlignW-1:0]     div_ff;
   logic [sefa_pkg::AlignW-1:0]     rem_ff;
   logic [sefa_pkg::RndCntW-1:0]    cnt_ff;
   logic [sefa_pkg::ValW-1:0]       rounded_ff;
   logic                            done_ff;
   logic                            exact_ff;
   logic [sefa_pkg::AlignW:0]       trial;
   logic [sefa_pkg::AlignW-1:0]     pad;

   assign trial = {rem_ff, shift_ff[sefa_pkg::ValW-1]};
   assign pad   = (rem_ff == '0) ? '0 : div_ff - rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            R_IDLE: begin
               if (start) begin
                  orig_ff  <= value;
                  shift_ff <= value;
                  div_ff   <= (align == '0) ? sefa_pkg::AlignW'(1) : align;
                  rem_ff   <= '0;
                  cnt_ff   <= sefa_pkg::RndCntW'(sefa_pkg::ValW);
                  state_ff <= R_DIV;
               end
            end
            R_DIV: begin
               if (trial >= {1'b0, div_ff}) begin
                  rem_ff <= sefa_pkg::AlignW'(trial - {1'b0, div_ff});
               end else begin
                  rem_ff <= trial[sefa_pkg::AlignW-1:0];
               end
               shift_ff <= {shift_ff[sefa_pkg::ValW-2:0], 1'b0};
               cnt_ff   <= cnt_ff - sefa_pkg::RndCntW'(1);
               if (cnt_ff == sefa_pkg::RndCntW'(1)) begin
                  state_ff <= R_FIX;
               end
            end
            R_FIX: begin
               rounded_ff <= orig_ff + sefa_pkg::ValW'(pad);
               exact_ff   <= (rem_ff == '0);
               done_ff    <= 1'b1;
               state_ff   <= R_IDLE;
            end
            default: state_ff <= R_IDLE;
         endcase
      end
   end

   assign rounded    = rounded_ff;
   assign stat.done  = done_ff;
   assign stat.exact = exact_ff;

endmodule

FILE: sv/sorted_extent_first_fit_allocator_unit.sv
// Sorted extent table with first-fit allocation.
// Requests come in on req_valid/req_ready with a sefa_req_type payload;
// one response per request leaves on rsp_valid/rsp_ready (sefa_rsp_type).
// The csr_ port writes reserve_bytes (index 0) and align_bytes (index 1);
// the user must do so only while no request is in flight; no guard exists.
// One request is worked at a time; req_ready is high only in idle.
// The work per request is set by the extent RAM (one write, one read port)
// and the shared rounding unit, which works one remainder bit per cycle:
//   limit, nth, unknown mode:  at most one RAM read
//   size query, free search:   one RAM read per binary-search probe
//   free close-up:             one read and one write per entry moved
//   first-fit, statistics:     one round-up per extent walked
//   alloc-at:                  one round-up, a read per scanned entry
//                              and a read and a write per moved entry
// A finished response sits in the output register; a new request may be
// taken meanwhile and its response waits until the old one is taken.
// Synchronous reset empties the table (count to zero), restores the
// csr_ registers, and drops rsp_valid. No RAM clearing pass is needed.
module sorted_extent_first_fit_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sefa_pkg::sefa_req_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sefa_pkg::sefa_rsp_type         rsp_data,
   input  logic                           csr_we,
   input  logic [sefa_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [sefa_pkg::CsrDataW-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_BASE, S_WALK_RD, S_WALK_DAT, S_WALK_RND, S_GAP, S_PLACE,
      S_INS_GO, S_UP_RD, S_UP_WR, S_INS_WR, S_BS_RD, S_BS_DAT, S_DN_RD,
      S_DN_WR, S_RD_ONE, S_RD_DAT, S_RESP
   } state_type;

   localparam int CntW = sefa_pkg::CntW;
   localparam int IdxW = sefa_pkg::IdxW;
   localparam int ValW = sefa_pkg::ValW;
   localparam int AB   = sefa_pkg::AddrBits;

   // configuration
   logic [sefa_pkg::ReserveW-1:0] reserve_ff;
   logic [sefa_pkg::AlignW-1:0]   align_ff;

   // sequencer state
   state_type state_ff, state_in;
   sefa_pkg::sefa_req_type req_ff, req_in;
   sefa_pkg::sefa_rsp_type res_ff, res_in;
   sefa_pkg::sefa_rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] i_ff, i_in;
   logic [CntW-1:0] lo_ff, lo_in;
   logic [CntW-1:0] hi_ff, hi_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [ValW-1:0] cand_ff, cand_in;
   logic [AB-1:0]   gap_ff, gap_in;
   logic            gap_ok_ff, gap_ok_in;
   logic            gap_last_ff, gap_last_in;
   logic            rnd_start_ff, rnd_start_in;
   logic [ValW-1:0] rnd_val_ff, rnd_val_in;

   // extent RAM
   logic                    ram_we;
   logic [IdxW-1:0]         ram_waddr;
   logic [IdxW-1:0]         ram_raddr;
   sefa_pkg::sefa_entry_type ram_wdata;
   sefa_pkg::sefa_entry_type ram_rdata;

   // rounding unit
   logic [ValW-1:0]             rnd_rounded;
   sefa_pkg::sefa_rnd_stat_type rnd_stat;

   // datapath helpers
   logic [ValW:0]              cand_plus_size;
   logic [AB:0]                end_sum;
   logic [AB:0]                off_plus_size;
   logic [CntW:0]              mid_sum;
   logic [CntW-1:0]            mid;
   logic [AB:0]                bytes_sum;
   logic [sefa_pkg::CmpW-1:0]  idx_ext;
   logic [sefa_pkg::CmpW-1:0]  cnt_ext;

   sefa_ram #(
      .Width ($bits(sefa_pkg::sefa_entry_type)),
      .Depth (sefa_pkg::MaxExtents)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sefa_rnd u_rnd (
      .clock   (clock),
      .reset   (reset),
      .start   (rnd_start_ff),
      .value   (rnd_val_ff),
      .align   (align_ff),
      .rounded (rnd_rounded),
      .stat    (rnd_stat)
   );

   assign cand_plus_size = {1'b0, cand_ff} + (ValW+1)'(req_ff.req_size);
   assign end_sum        = {1'b0, ram_rdata.off} + {1'b0, ram_rdata.size};
   assign off_plus_size  = {1'b0, req_ff.req_offset} + {1'b0, req_ff.req_size};
   assign mid_sum        = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid            = mid_sum[CntW:1];
   assign bytes_sum      = {1'b0, res_ff.free_bytes} + {1'b0, gap_ff};
   assign idx_ext        = sefa_pkg::CmpW'(req_data.layout_index);
   assign cnt_ext        = sefa_pkg::CmpW'(cnt_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pos_in       = pos_ff;
      cand_in      = cand_ff;
      gap_in       = gap_ff;
      gap_ok_in    = gap_ok_ff;
      gap_last_in  = gap_last_ff;
      rnd_start_in = 1'b0;
      rnd_val_in   = rnd_val_ff;
      ram_we       = 1'b0;
      ram_waddr    = i_ff[IdxW-1:0];
      ram_wdata    = ram_rdata;
      ram_raddr    = i_ff[IdxW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               res_in   = '0;
               i_in     = '0;
               state_in = S_RESP;
               unique case (req_data.mode)
                  sefa_pkg::ModeFirstFit, sefa_pkg::ModeStats: begin
                     if (req_data.mode == sefa_pkg::ModeFirstFit &&
                         cnt_ff == CntW'(sefa_pkg::MaxExtents)) begin
                        res_in.status = sefa_pkg::StFull;
                     end else begin
                        rnd_start_in = 1'b1;
                        rnd_val_in   = ValW'(reserve_ff);
                        state_in     = S_BASE;
                     end
                  end
                  sefa_pkg::ModeAllocAt: begin
                     if (cnt_ff == CntW'(sefa_pkg::MaxExtents)) begin
                        res_in.status = sefa_pkg::StFull;
                     end else begin
                        rnd_start_in = 1'b1;
                        rnd_val_in   = ValW'(req_data.req_offset);
                        state_in     = S_BASE;
                     end
                  end
                  sefa_pkg::ModeFree, sefa_pkg::ModeSizeQ: begin
                     lo_in    = '0;
                     hi_in    = cnt_ff;
                     state_in = S_BS_RD;
                  end
                  sefa_pkg::ModeLimit: begin
                     if (cnt_ff == '0) begin
                        res_in.result_offset = AB'(reserve_ff);
                     end else begin
                        i_in     = cnt_ff - CntW'(1);
                        state_in = S_RD_ONE;
                     end
                  end
                  sefa_pkg::ModeNth: begin
                     if (req_data.layout_index == '0) begin
                        res_in.result_size = AB'(reserve_ff);
                     end else if (idx_ext > cnt_ext) begin
                        res_in.status = sefa_pkg::StBadIndex;
                     end else begin
                        i_in     = CntW'(idx_ext - sefa_pkg::CmpW'(1));
                        state_in = S_RD_ONE;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_BASE: begin
            if (rnd_stat.done) begin
               if (req_ff.mode == sefa_pkg::ModeAllocAt) begin
                  if (!rnd_stat.exact || req_ff.req_offset < AB'(reserve_ff)) begin
                     res_in.status = sefa_pkg::StBadOffset;
                     state_in      = S_RESP;
                  end else if (off_plus_size[AB]) begin
                     res_in.status = sefa_pkg::StOverflow;
                     state_in      = S_RESP;
                  end else begin
                     cand_in  = ValW'(req_ff.req_offset);
                     state_in = S_WALK_RD;
                  end
               end else begin
                  cand_in  = rnd_rounded;
                  state_in = S_WALK_RD;
               end
            end
         end

         // walk the table in offset order, one entry per visit
         S_WALK_RD: begin
            if (i_ff == cnt_ff) begin
               pos_in = cnt_ff;
               priority case (req_ff.mode)
                  sefa_pkg::ModeFirstFit: state_in = S_PLACE;
                  sefa_pkg::ModeAllocAt:  state_in = S_INS_GO;
                  default: begin
                     gap_ok_in   = ValW'(req_ff.file_size) > cand_ff;
                     gap_in      = req_ff.file_size - cand_ff[AB-1:0];
                     gap_last_in = 1'b1;
                     state_in    = S_GAP;
                  end
               endcase
            end else begin
               state_in = S_WALK_DAT;
            end
         end

         S_WALK_DAT: begin
            priority case (req_ff.mode)
               sefa_pkg::ModeFirstFit: begin
                  if (cand_plus_size <= (ValW+1)'(ram_rdata.off)) begin
                     pos_in   = i_ff;
                     state_in = S_PLACE;
                  end else begin
                     rnd_start_in = 1'b1;
                     rnd_val_in   = ValW'(end_sum);
                     state_in     = S_WALK_RND;
                  end
               end
               sefa_pkg::ModeAllocAt: begin
                  if (ram_rdata.off > req_ff.req_offset) begin
                     pos_in   = i_ff;
                     state_in = S_INS_GO;
                  end else begin
                     i_in     = i_ff + CntW'(1);
                     state_in = S_WALK_RD;
                  end
               end
               default: begin
                  gap_ok_in    = ValW'(ram_rdata.off) > cand_ff;
                  gap_in       = ram_rdata.off - cand_ff[AB-1:0];
                  gap_last_in  = 1'b0;
                  rnd_start_in = 1'b1;
                  rnd_val_in   = ValW'(end_sum);
                  state_in     = S_GAP;
               end
            endcase
         end

         S_WALK_RND: begin
            if (rnd_stat.done) begin
               cand_in  = rnd_rounded;
               i_in     = i_ff + CntW'(1);
               state_in = S_WALK_RD;
            end
         end

         // fold one gap into the statistics, saturating
         S_GAP: begin
            if (gap_ok_ff) begin
               res_in.free_bytes = bytes_sum[AB] ? sefa_pkg::Mask48 : bytes_sum[AB-1:0];
               if (res_ff.free_gaps != '1) begin
                  res_in.free_gaps = res_ff.free_gaps + sefa_pkg::GapsW'(1);
               end
               if (gap_ff > res_ff.largest_gap) begin
                  res_in.largest_gap = gap_ff;
               end
            end
            state_in = gap_last_ff ? S_RESP : S_WALK_RND;
         end

         S_PLACE: begin
            if (|cand_plus_size[ValW:AB]) begin
               res_in.status = sefa_pkg::StOverflow;
               state_in      = S_RESP;
            end else begin
               state_in = S_INS_GO;
            end
         end

         S_INS_GO: begin
            if (pos_ff == cnt_ff) begin
               state_in = S_INS_WR;
            end else begin
               i_in     = cnt_ff - CntW'(1);
               state_in = S_UP_RD;
            end
         end

         // open a slot: move entries up from the tail down to pos
         S_UP_RD: state_in = S_UP_WR;

         S_UP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = IdxW'(i_ff + CntW'(1));
            if (i_ff == pos_ff) begin
               state_in = S_INS_WR;
            end else begin
               i_in     = i_ff - CntW'(1);
               state_in = S_UP_RD;
            end
         end

         S_INS_WR: begin
            ram_we               = 1'b1;
            ram_waddr            = pos_ff[IdxW-1:0];
            ram_wdata.off        = cand_ff[AB-1:0];
            ram_wdata.size       = req_ff.req_size;
            cnt_in               = cnt_ff + CntW'(1);
            res_in.result_offset = cand_ff[AB-1:0];
            state_in             = S_RESP;
         end

         S_BS_RD: begin
            if (lo_ff < hi_ff) begin
               ram_raddr = mid[IdxW-1:0];
               i_in      = mid;
               state_in  = S_BS_DAT;
            end else begin
               res_in.status = sefa_pkg::StNotFound;
               state_in      = S_RESP;
            end
         end

         S_BS_DAT: begin
            if (ram_rdata.off < req_ff.req_offset) begin
               lo_in    = i_ff + CntW'(1);
               state_in = S_BS_RD;
            end else if (ram_rdata.off > req_ff.req_offset) begin
               hi_in    = i_ff;
               state_in = S_BS_RD;
            end else if (req_ff.mode == sefa_pkg::ModeSizeQ) begin
               res_in.result_size = ram_rdata.size;
               state_in           = S_RESP;
            end else if (i_ff + CntW'(1) == cnt_ff) begin
               cnt_in   = cnt_ff - CntW'(1);
               state_in = S_RESP;
            end else begin
               i_in     = i_ff + CntW'(1);
               state_in = S_DN_RD;
            end
         end

         // close up after a free: move later entries down by one
         S_DN_RD: state_in = S_DN_WR;

         S_DN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = IdxW'(i_ff - CntW'(1));
            if (i_ff + CntW'(1) == cnt_ff) begin
               cnt_in   = cnt_ff - CntW'(1);
               state_in = S_RESP;
            end else begin
               i_in     = i_ff + CntW'(1);
               state_in = S_DN_RD;
            end
         end

         S_RD_ONE: state_in = S_RD_DAT;

         S_RD_DAT: begin
            if (req_ff.mode == sefa_pkg::ModeLimit) begin
               res_in.result_offset = end_sum[AB-1:0];
            end else begin
               res_in.result_offset = ram_rdata.off;
               res_in.result_size   = ram_rdata.size;
            end
            state_in = S_RESP;
         end

         // hand off to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rnd_start_ff <= 1'b0;
         reserve_ff   <= '0;
         align_ff     <= sefa_pkg::AlignReset;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         rnd_start_ff <= rnd_start_in;
         if (csr_we) begin
            unique case (csr_index)
               sefa_pkg::CsrReserve: reserve_ff <= csr_wdata;
               sefa_pkg::CsrAlign:   align_ff   <= csr_wdata[sefa_pkg::AlignW-1:0];
               default:              reserve_ff <= reserve_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      i_ff        <= i_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      pos_ff      <= pos_in;
      cand_ff     <= cand_in;
      gap_ff      <= gap_in;
      gap_ok_ff   <= gap_ok_in;
      gap_last_ff <= gap_last_in;
      rnd_val_ff  <= rnd_val_in;
   end

   // table never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(sefa_pkg::MaxExtents))
      else $error("extent count above capacity");

   // count moves by at most one per request
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
         (cnt_ff == $past(cnt_ff) + CntW'(1) || cnt_ff == $past(cnt_ff) - CntW'(1)))
      else $error("extent count jumped");

   // rounding results arrive only while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      rnd_stat.done |-> (state_ff == S_BASE || state_ff == S_WALK_RND))
      else $error("rounding result dropped");

   // an error response carries no offset or size
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != sefa_pkg::StOk) |->
         (rsp_ff.result_offset == '0 && rsp_ff.result_size == '0))
      else $error("error response with payload");

endmodule
